>>> design/substring_search_modes_defines.svh
// ----------------------------------------------------------------------------
// substring search assertion macros
// clocked assertion helpers used by the substring search tally
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_SEARCH_MODES_DEFINES_SVH
`define SUBSTRING_SEARCH_MODES_DEFINES_SVH

`ifndef SYNTHESIS
// check held off while reset is asserted
`define SSM_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that holds at every edge, reset included
`define SSM_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSM_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SSM_ASSERT_ALL(lbl, clk, prop, msg)
`endif

`endif

>>> design/ssm_pkg.sv
// ----------------------------------------------------------------------------
// substring search package
// shared constants, mode codes and control structs
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int MAX_PATTERN_LENGTH = 8;
    localparam int TEXT_INDEX_BITS    = 16;
    localparam int ANSWER_WIDTH       = 17;
    localparam int PATTERN_WIDTH      = 64;
    localparam int LENGTH_WIDTH       = 4;
    localparam int MODE_WIDTH         = 2;
    localparam int REG_INDEX_WIDTH    = 2;

    // match modes
    localparam logic [MODE_WIDTH-1:0] MODE_ANY   = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_COUNT = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_FIRST = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_NONE  = 2'd3;

    // register indexes
    localparam logic [REG_INDEX_WIDTH-1:0] REG_PATTERN = 2'd0;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_LENGTH  = 2'd1;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_MODE    = 2'd2;

    // control handed to every window cell
    typedef struct packed {
        logic                    shift;
        logic                    clear;
        logic [LENGTH_WIDTH-1:0] eff_len;
    } t_cell_ctrl;

    // per-transfer step handed to the tally
    typedef struct packed {
        logic accept;
        logic last;
        logic hit;
    } t_step;

endpackage

>>> design/ssm_if.sv
// ----------------------------------------------------------------------------
// substring search channels
// valid/ready interfaces for text input, result output and configuration
// ----------------------------------------------------------------------------
interface ssm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface ssm_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ssm_pkg::ANSWER_WIDTH-1:0] answer_value;
    logic                                    match_seen;

    modport source (output valid, output answer_value, output match_seen, input ready);
    modport sink   (input valid, input answer_value, input match_seen, output ready);
endinterface

interface ssm_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ssm_pkg::REG_INDEX_WIDTH-1:0]  reg_index;
    logic [ssm_pkg::PATTERN_WIDTH-1:0]    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> design/ssm_cell.sv
// ----------------------------------------------------------------------------
// substring search window cell
// holds one window byte, passes it on, compares against its pattern byte
// ----------------------------------------------------------------------------
module ssm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssm_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [ssm_pkg::PATTERN_WIDTH-1:0]   i_pattern,
    input  logic [7:0]                          i_byte,
    input  logic                                i_fill,
    output logic [7:0]                          o_byte,
    output logic                                o_fill,
    output logic                                o_hit
);

    localparam logic [ssm_pkg::LENGTH_WIDTH-1:0] K = ssm_pkg::LENGTH_WIDTH'(CELL_INDEX);

    logic [7:0] r_byte;
    logic       r_fill;
    logic [ssm_pkg::LENGTH_WIDTH-1:0] w_sel_wide;
    logic [2:0] w_sel;
    logic [7:0] w_want;

    // pattern byte that lands on this cell for the current length
    assign w_sel_wide = i_ctrl.eff_len - K - ssm_pkg::LENGTH_WIDTH'(1);
    assign w_sel      = w_sel_wide[2:0];
    assign w_want     = i_pattern[{w_sel, 3'b000} +: 8];

    // cells beyond the pattern length never block a match
    assign o_hit = (K >= i_ctrl.eff_len) || (i_fill && (i_byte == w_want));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_fill <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_fill <= i_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_fill = r_fill;

endmodule

>>> design/ssm_tally.sv
// ----------------------------------------------------------------------------
// substring search tally
// position and match counters, mode select and result register
// ----------------------------------------------------------------------------
`include "substring_search_modes_defines.svh"

module ssm_tally #(
    parameter int TEXT_INDEX_BITS = ssm_pkg::TEXT_INDEX_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  ssm_pkg::t_step                           i_step,
    input  logic [ssm_pkg::MODE_WIDTH-1:0]           i_mode,
    input  logic [ssm_pkg::LENGTH_WIDTH-1:0]         i_eff_len,
    input  logic                                     i_out_ready,
    output logic                                     o_in_ready,
    output logic                                     o_out_valid,
    output logic signed [ssm_pkg::ANSWER_WIDTH-1:0]  o_answer,
    output logic                                     o_seen
);

    localparam int IW = TEXT_INDEX_BITS;
    localparam int AW = ssm_pkg::ANSWER_WIDTH;
    localparam logic [IW-1:0] IDX_MAX = {IW{1'b1}};

    logic [IW-1:0] r_byte_index, n_byte_index;
    logic [IW-1:0] r_match_total, n_match_total;
    logic [IW-1:0] r_first_start, n_first_start;
    logic          r_first_valid, n_first_valid;
    logic [IW:0]   w_start_wide;
    logic          w_match;
    logic signed [AW-1:0] w_answer;
    logic                 r_out_valid;
    logic signed [AW-1:0] r_answer;
    logic                 r_seen;

    assign w_match      = i_step.accept && i_step.hit;
    assign w_start_wide = {1'b0, r_byte_index} + (IW+1)'(1) - (IW+1)'(i_eff_len);

    always_comb begin
        n_byte_index  = r_byte_index;
        n_match_total = r_match_total;
        n_first_start = r_first_start;
        n_first_valid = r_first_valid;
        if (i_step.accept && (r_byte_index != IDX_MAX)) begin
            n_byte_index = r_byte_index + IW'(1);
        end
        if (w_match) begin
            if (r_match_total != IDX_MAX) begin
                n_match_total = r_match_total + IW'(1);
            end
            if (!r_first_valid) begin
                n_first_valid = 1'b1;
                n_first_start = w_start_wide[IW-1:0];
            end
        end
    end

    always_comb begin
        unique case (i_mode)
            ssm_pkg::MODE_ANY:   w_answer = n_first_valid ? AW'(1) : AW'(0);
            ssm_pkg::MODE_COUNT: w_answer = AW'(n_match_total);
            ssm_pkg::MODE_FIRST: w_answer = n_first_valid ? AW'(n_first_start) : '1;
            ssm_pkg::MODE_NONE:  w_answer = '1;
            default:             w_answer = '1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index  <= '0;
            r_match_total <= '0;
            r_first_start <= '0;
            r_first_valid <= 1'b0;
        end else if (i_step.accept && i_step.last) begin
            r_byte_index  <= '0;
            r_match_total <= '0;
            r_first_start <= '0;
            r_first_valid <= 1'b0;
        end else begin
            r_byte_index  <= n_byte_index;
            r_match_total <= n_match_total;
            r_first_start <= n_first_start;
            r_first_valid <= n_first_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step.accept && i_step.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.accept && i_step.last) begin
            r_answer <= w_answer;
            r_seen   <= n_first_valid;
        end
    end

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_seen      = r_seen;

    `SSM_ASSERT_RST(a_first_tracks_total, i_clk, i_rst_n,
        r_first_valid == (r_match_total != '0),
        "first match flag disagrees with match count")
    `SSM_ASSERT_RST(a_first_before_index, i_clk, i_rst_n,
        r_first_valid |-> (r_first_start <= r_byte_index),
        "first start beyond current position")
    `SSM_ASSERT_RST(a_final_clears, i_clk, i_rst_n,
        (i_step.accept && i_step.last) |=>
            (r_out_valid && (r_byte_index == '0) && !r_first_valid),
        "final byte did not load result and clear string state")

endmodule

>>> design/substring_search_modes.sv
// ----------------------------------------------------------------------------
// substring search modes
// streaming pattern search over a row of window cells, one result per string
// ----------------------------------------------------------------------------
//  channel   dir  payload                          transfer when
//  i_text    in   text_byte[7:0], last_byte        valid && ready
//  o_result  out  answer_value[16:0] s, match_seen valid && ready
//  i_cfg     in   reg_index[1:0], wr_data[63:0]    valid && ready (always ready)
//
//  one text byte per cycle; the byte window and the compare sit in the cell row
//  the result of a string is registered on the edge that takes its last byte
//  and is shown from the next cycle on
//  synchronous active-low reset clears pattern, mode, cell fill flags and counters, sets length to one
//  a waiting result stalls input only while the result is not being taken
// ----------------------------------------------------------------------------
module substring_search_modes #(
    parameter int MAX_PATTERN_LENGTH = ssm_pkg::MAX_PATTERN_LENGTH,
    parameter int TEXT_INDEX_BITS    = ssm_pkg::TEXT_INDEX_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssm_in_if.sink     i_text,
    ssm_out_if.source  o_result,
    ssm_cfg_if.sink    i_cfg
);

    localparam int LW = ssm_pkg::LENGTH_WIDTH;

    // configuration registers
    logic [ssm_pkg::PATTERN_WIDTH-1:0] r_pattern;
    logic [LW-1:0]                     r_length;
    logic [ssm_pkg::MODE_WIDTH-1:0]    r_mode;

    logic [LW-1:0]        w_eff_len;
    logic                 w_accept;
    logic                 w_in_ready;
    ssm_pkg::t_cell_ctrl  w_ctrl;
    ssm_pkg::t_step       w_step;

    // cell row wiring
    logic [7:0]                    w_byte [MAX_PATTERN_LENGTH];
    logic [MAX_PATTERN_LENGTH-1:0] w_fill;
    logic [MAX_PATTERN_LENGTH-1:0] w_hit;

    // config writes are taken every cycle; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= LW'(1);
            r_mode    <= ssm_pkg::MODE_ANY;
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == ssm_pkg::REG_PATTERN) begin
                r_pattern <= i_cfg.wr_data;
            end
            if (i_cfg.reg_index == ssm_pkg::REG_LENGTH) begin
                r_length <= i_cfg.wr_data[LW-1:0];
            end
            if (i_cfg.reg_index == ssm_pkg::REG_MODE) begin
                r_mode <= i_cfg.wr_data[ssm_pkg::MODE_WIDTH-1:0];
            end
        end
    end

    // length zero acts as one, anything past the row acts as the full row
    always_comb begin
        priority if (r_length == '0) begin
            w_eff_len = LW'(1);
        end else if (r_length > LW'(MAX_PATTERN_LENGTH)) begin
            w_eff_len = LW'(MAX_PATTERN_LENGTH);
        end else begin
            w_eff_len = r_length;
        end
    end

    assign w_accept = i_text.valid && w_in_ready;
    assign i_text.ready = w_in_ready;

    assign w_ctrl.shift   = w_accept;
    assign w_ctrl.clear   = w_accept && i_text.last_byte;
    assign w_ctrl.eff_len = w_eff_len;

    // cell 0 takes the incoming byte, each later cell takes its neighbor's byte
    for (genvar k = 0; k < MAX_PATTERN_LENGTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            ssm_cell #(
                .CELL_INDEX (k)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_pattern (r_pattern),
                .i_byte    (i_text.text_byte),
                .i_fill    (1'b1),
                .o_byte    (w_byte[k]),
                .o_fill    (w_fill[k]),
                .o_hit     (w_hit[k])
            );
        end else begin : g_body
            ssm_cell #(
                .CELL_INDEX (k)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_pattern (r_pattern),
                .i_byte    (w_byte[k-1]),
                .i_fill    (w_fill[k-1]),
                .o_byte    (w_byte[k]),
                .o_fill    (w_fill[k]),
                .o_hit     (w_hit[k])
            );
        end
    end

    // a match needs every cell inside the pattern length to agree
    assign w_step.accept = w_accept;
    assign w_step.last   = i_text.last_byte;
    assign w_step.hit    = &w_hit;

    ssm_tally #(
        .TEXT_INDEX_BITS (TEXT_INDEX_BITS)
    ) u_tally (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_mode      (r_mode),
        .i_eff_len   (w_eff_len),
        .i_out_ready (o_result.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (o_result.valid),
        .o_answer    (o_result.answer_value),
        .o_seen      (o_result.match_seen)
    );

endmodule
